// File: hw/rtl/rvx_pkg.sv
// shared types and constants for the rv32i execute unit
// no dependencies; imported by every module of the block but rvx_ram
package rvx_pkg;

    localparam int REG_COUNT   = 32;
    localparam int RA_W        = 5;
    localparam int RF_DEPTH    = 1 << RA_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] OP_ALU_R  = 7'h33;
    localparam logic [6:0] OP_ALU_I  = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_MISC   = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0]  F7_BASE  = 7'h00;
    localparam logic [6:0]  F7_ALT   = 7'h20;
    localparam logic [31:0] INSTR_EBREAK = 32'h0010_0073;
    localparam logic [31:0] INSTR_ECALL  = 32'h0000_0073;
    localparam logic [31:0] CALL_WRITE   = 32'd64;
    localparam logic [31:0] CALL_EXIT    = 32'd93;
    localparam logic [31:0] FD_STDOUT    = 32'd1;
    localparam logic [31:0] FD_STDERR    = 32'd2;
    localparam logic [RA_W-1:0] REG_A0 = 5'd10;
    localparam logic [RA_W-1:0] REG_A1 = 5'd11;
    localparam logic [RA_W-1:0] REG_A2 = 5'd12;
    localparam logic [RA_W-1:0] REG_A7 = 5'd17;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LWX  = 3'd3;
    localparam logic [2:0] F3_LHU  = 3'd5;

    localparam logic [2:0] PK_NONE = 3'd0;
    localparam logic [2:0] PK_LB   = 3'd1;
    localparam logic [2:0] PK_LH   = 3'd2;
    localparam logic [2:0] PK_LW   = 3'd3;
    localparam logic [2:0] PK_LBU  = 3'd4;
    localparam logic [2:0] PK_LHU  = 3'd5;

    typedef enum logic [2:0] {
        ST_OK, ST_EBREAK, ST_EXIT, ST_WRITE,
        ST_ILLEGAL, ST_MISALIGN, ST_BAD_STREAM, ST_UNKNOWN
    } status_t;

    typedef enum logic [1:0] {MOP_NONE, MOP_LOAD, MOP_STORE} mem_op_t;
    typedef enum logic [1:0] {SZ_BYTE, SZ_HALF, SZ_WORD} mem_size_t;

    typedef enum logic [3:0] {
        C_ALU_R, C_ALU_I, C_LOAD, C_STORE, C_BRANCH, C_JAL, C_JALR,
        C_LUI, C_AUIPC, C_NOP, C_EBREAK, C_ECALL, C_ILLEGAL, C_LRET
    } cls_t;

    typedef struct packed {
        cls_t            cls;
        logic [2:0]      f3;
        logic            alt;
        logic [RA_W-1:0] rd;
        logic [RA_W-1:0] rs1;
        logic [RA_W-1:0] rs2;
        logic [31:0]     imm;
        logic [31:0]     pc;
        logic [31:0]     ld;
    } qent_t;

    typedef struct packed {
        logic            fire;
        logic            wen;
        logic [RA_W-1:0] waddr;
    } bk_stat_t;

endpackage

// File: hw/rtl/rvx_ram.sv
// generic single write, single registered read memory
// no dependencies
module rvx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule

// File: hw/rtl/rvx_front.sv
// front end: takes input beats and classifies them into queue entries
// depends on rvx_pkg
module rvx_front (
    input  logic          s_mode,
    input  logic [31:0]   s_instr,
    input  logic [31:0]   s_instr_addr,
    input  logic [31:0]   s_load_data,
    output rvx_pkg::qent_t ent
);
    import rvx_pkg::*;

    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] iimm, simm, bimm, jimm, uimm;

    assign op = s_instr[6:0];
    assign f3 = s_instr[14:12];
    assign f7 = s_instr[31:25];
    assign iimm = {{20{s_instr[31]}}, s_instr[31:20]};
    assign simm = {{20{s_instr[31]}}, s_instr[31:25], s_instr[11:7]};
    assign bimm = {{19{s_instr[31]}}, s_instr[31], s_instr[7], s_instr[30:25],
                   s_instr[11:8], 1'b0};
    assign jimm = {{11{s_instr[31]}}, s_instr[31], s_instr[19:12], s_instr[20],
                   s_instr[30:21], 1'b0};
    assign uimm = {s_instr[31:12], 12'b0};

    always_comb begin
        ent.cls = C_ILLEGAL;
        ent.f3  = f3;
        ent.alt = 1'b0;
        ent.rd  = s_instr[11:7];
        ent.rs1 = s_instr[19:15];
        ent.rs2 = s_instr[24:20];
        ent.imm = '0;
        ent.pc  = s_instr_addr;
        ent.ld  = s_load_data;
        if (s_mode) begin
            ent.cls = C_LRET;
        end else begin
            case (op)
                OP_ALU_R: begin
                    if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
                        ent.cls = C_ALU_R;
                        ent.alt = (f7 == F7_ALT);
                    end
                end
                OP_ALU_I: begin
                    if (!((f3 == F3_SLL && f7 != F7_BASE) ||
                          (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT))) begin
                        ent.cls = C_ALU_I;
                        ent.imm = iimm;
                        ent.alt = (f3 == F3_SR && f7 == F7_ALT);
                    end
                end
                OP_LOAD: begin
                    if (f3 != F3_LWX && f3 <= F3_LHU) begin
                        ent.cls = C_LOAD;
                        ent.imm = iimm;
                    end
                end
                OP_STORE: begin
                    if (f3 <= F3_LW) begin
                        ent.cls = C_STORE;
                        ent.imm = simm;
                    end
                end
                OP_BRANCH: begin
                    if (f3 != 3'd2 && f3 != 3'd3) begin
                        ent.cls = C_BRANCH;
                        ent.imm = bimm;
                    end
                end
                OP_JAL: begin
                    ent.cls = C_JAL;
                    ent.imm = jimm;
                end
                OP_JALR: begin
                    if (f3 == F3_ADD) begin
                        ent.cls = C_JALR;
                        ent.imm = iimm;
                    end
                end
                OP_LUI: begin
                    ent.cls = C_LUI;
                    ent.imm = uimm;
                end
                OP_AUIPC: begin
                    ent.cls = C_AUIPC;
                    ent.imm = uimm;
                end
                OP_MISC: begin
                    ent.cls = C_NOP;
                end
                OP_SYSTEM: begin
                    if (s_instr == INSTR_EBREAK) begin
                        ent.cls = C_EBREAK;
                    end else if (s_instr == INSTR_ECALL) begin
                        ent.cls = C_ECALL;
                    end
                end
                default: begin
                    ent.cls = C_ILLEGAL;
                end
            endcase
        end
    end
endmodule

// File: hw/rtl/rvx_queue.sv
// short queue of classified entries between front and back
// depends on rvx_pkg
module rvx_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  rvx_pkg::qent_t           push_ent,
    input  logic                     pop,
    output logic                     not_empty,
    output logic                     full,
    output logic [rvx_pkg::QC_W-1:0] count,
    output rvx_pkg::qent_t           head
);
    import rvx_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    qent_t           ent_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [QC_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QC_W'(QUEUE_DEPTH));
    assign count     = count_reg;
    assign head      = ent_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wptr_reg] <= push_ent;
        end
    end
endmodule

// File: hw/rtl/rvx_back.sv
// back end: register file read, execute, write back and output register
// depends on rvx_pkg and rvx_ram
module rvx_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  rvx_pkg::qent_t       q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [31:0]          m_next_pc,
    output logic [1:0]           m_mem_op,
    output logic [1:0]           m_mem_size,
    output logic [31:0]          m_mem_addr,
    output logic [31:0]          m_mem_wdata,
    output logic                 m_stream_sel,
    output rvx_pkg::bk_stat_t    stat
);
    import rvx_pkg::*;

    logic                b_valid_reg;
    qent_t               b_reg;
    logic                fwd1_reg, fwd2_reg, vld1_reg, vld2_reg;
    logic [31:0]         fdat_reg;
    logic [RF_DEPTH-1:0] vbits_reg;
    logic [31:0]         a0_reg, a1_reg, a2_reg, a7_reg;
    logic [RA_W-1:0]     prd_reg;
    logic [2:0]          pkind_reg;
    logic                m_valid_reg;
    logic [2:0]          st_reg;
    logic [31:0]         npc_reg, maddr_reg, wd_reg;
    logic [1:0]          mop_reg, msz_reg;
    logic                ss_reg;

    logic            fire;
    logic [31:0]     q1, q2, a, b, opb, alu_r, sum_ab, pc4, pc_imm, lv;
    logic            wen, wr_ok;
    logic [RA_W-1:0] waddr, prd_next;
    logic [31:0]     wdata;
    logic [2:0]      pkind_next;
    status_t         st;
    logic [31:0]     npc, maddr, wd;
    mem_op_t         mop;
    mem_size_t       msz;
    logic            ss, taken;

    assign fire  = b_valid_reg && (!m_valid_reg || m_ready);
    assign q_pop = q_valid && (!b_valid_reg || fire);

    rvx_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf1 (
        .aclk(aclk), .we(wen), .waddr(waddr), .wdata(wdata),
        .re(q_pop), .raddr(q_head.rs1), .rdata(q1)
    );
    rvx_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf2 (
        .aclk(aclk), .we(wen), .waddr(waddr), .wdata(wdata),
        .re(q_pop), .raddr(q_head.rs2), .rdata(q2)
    );

    // operands with bypass of the write landing in the read cycle
    assign a = fwd1_reg ? fdat_reg : (vld1_reg ? q1 : '0);
    assign b = fwd2_reg ? fdat_reg : (vld2_reg ? q2 : '0);
    assign opb    = (b_reg.cls == C_ALU_R) ? b : b_reg.imm;
    assign sum_ab = a + b_reg.imm;
    assign pc4    = b_reg.pc + 32'd4;
    assign pc_imm = b_reg.pc + b_reg.imm;

    always_comb begin
        case (b_reg.f3)
            F3_ADD:  alu_r = b_reg.alt ? a - opb : a + opb;
            F3_SLL:  alu_r = a << opb[4:0];
            F3_SLT:  alu_r = {31'b0, $signed(a) < $signed(opb)};
            F3_SLTU: alu_r = {31'b0, a < opb};
            F3_XOR:  alu_r = a ^ opb;
            F3_SR:   alu_r = b_reg.alt ? 32'($signed(a) >>> opb[4:0]) : a >> opb[4:0];
            F3_OR:   alu_r = a | opb;
            default: alu_r = a & opb;
        endcase
    end

    always_comb begin
        case (b_reg.f3)
            F3_BEQ:  taken = (a == b);
            F3_BNE:  taken = (a != b);
            F3_BLT:  taken = $signed(a) < $signed(b);
            F3_BGE:  taken = $signed(a) >= $signed(b);
            F3_BLTU: taken = a < b;
            F3_BGEU: taken = a >= b;
            default: taken = 1'b0;
        endcase
    end

    always_comb begin
        case (pkind_reg)
            PK_LB:   lv = {{24{b_reg.ld[7]}}, b_reg.ld[7:0]};
            PK_LH:   lv = {{16{b_reg.ld[15]}}, b_reg.ld[15:0]};
            PK_LBU:  lv = {24'b0, b_reg.ld[7:0]};
            PK_LHU:  lv = {16'b0, b_reg.ld[15:0]};
            default: lv = b_reg.ld;
        endcase
    end

    always_comb begin
        st         = ST_OK;
        npc        = pc4;
        mop        = MOP_NONE;
        msz        = SZ_BYTE;
        maddr      = '0;
        wd         = '0;
        ss         = 1'b0;
        wr_ok      = 1'b0;
        waddr      = b_reg.rd;
        wdata      = alu_r;
        prd_next   = prd_reg;
        pkind_next = pkind_reg;
        case (b_reg.cls)
            C_ALU_R, C_ALU_I: begin
                wr_ok = 1'b1;
            end
            C_LOAD: begin
                maddr = sum_ab;
                msz   = mem_size_t'(b_reg.f3[1:0]);
                if ((b_reg.f3[1:0] == 2'd1 && sum_ab[0]) ||
                    (b_reg.f3[1:0] == 2'd2 && sum_ab[1:0] != 2'b00)) begin
                    st  = ST_MISALIGN;
                    npc = b_reg.pc;
                end else begin
                    mop        = MOP_LOAD;
                    prd_next   = b_reg.rd;
                    pkind_next = (b_reg.f3 < F3_LWX) ? b_reg.f3 + 3'd1 : b_reg.f3;
                end
            end
            C_STORE: begin
                maddr = sum_ab;
                msz   = mem_size_t'(b_reg.f3[1:0]);
                if ((b_reg.f3[1:0] == 2'd1 && sum_ab[0]) ||
                    (b_reg.f3[1:0] == 2'd2 && sum_ab[1:0] != 2'b00)) begin
                    st  = ST_MISALIGN;
                    npc = b_reg.pc;
                end else begin
                    mop = MOP_STORE;
                    case (b_reg.f3[1:0])
                        2'd0:    wd = {24'b0, b[7:0]};
                        2'd1:    wd = {16'b0, b[15:0]};
                        default: wd = b;
                    endcase
                end
            end
            C_BRANCH: begin
                if (taken) begin
                    npc = pc_imm;
                end
            end
            C_JAL: begin
                wr_ok = 1'b1;
                wdata = pc4;
                npc   = pc_imm;
            end
            C_JALR: begin
                wr_ok = 1'b1;
                wdata = pc4;
                npc   = {sum_ab[31:1], 1'b0};
            end
            C_LUI: begin
                wr_ok = 1'b1;
                wdata = b_reg.imm;
            end
            C_AUIPC: begin
                wr_ok = 1'b1;
                wdata = pc_imm;
            end
            C_NOP: begin
                st = ST_OK;
            end
            C_EBREAK: begin
                st = ST_EBREAK;
            end
            C_ECALL: begin
                if (a7_reg == CALL_WRITE) begin
                    if (a0_reg == FD_STDOUT || a0_reg == FD_STDERR) begin
                        st    = ST_WRITE;
                        ss    = (a0_reg == FD_STDERR);
                        maddr = a1_reg;
                        wd    = a2_reg;
                        wr_ok = 1'b1;
                        waddr = REG_A0;
                        wdata = a2_reg;
                    end else begin
                        st  = ST_BAD_STREAM;
                        npc = b_reg.pc;
                    end
                end else if (a7_reg == CALL_EXIT) begin
                    st = ST_EXIT;
                    wd = a0_reg;
                end else begin
                    st  = ST_UNKNOWN;
                    npc = b_reg.pc;
                    wd  = a7_reg;
                end
            end
            C_LRET: begin
                npc = b_reg.pc;
                if (pkind_reg == PK_NONE || pkind_reg > PK_LHU) begin
                    st = ST_ILLEGAL;
                end else begin
                    wr_ok      = 1'b1;
                    waddr      = prd_reg;
                    wdata      = lv;
                    prd_next   = '0;
                    pkind_next = PK_NONE;
                end
            end
            default: begin
                st  = ST_ILLEGAL;
                npc = b_reg.pc;
            end
        endcase
    end

    // x0 and registers beyond the file are never written
    assign wen = fire && wr_ok && waddr != '0 && ({1'b0, waddr} < (RA_W + 1)'(REG_COUNT));

    assign stat.fire  = fire;
    assign stat.wen   = wen;
    assign stat.waddr = waddr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            vbits_reg   <= '0;
            a0_reg      <= '0;
            a1_reg      <= '0;
            a2_reg      <= '0;
            a7_reg      <= '0;
            prd_reg     <= '0;
            pkind_reg   <= PK_NONE;
        end else begin
            if (q_pop) begin
                b_valid_reg <= 1'b1;
            end else if (fire) begin
                b_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
                prd_reg     <= prd_next;
                pkind_reg   <= pkind_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (wen) begin
                vbits_reg[waddr] <= 1'b1;
                if (waddr == REG_A0) a0_reg <= wdata;
                if (waddr == REG_A1) a1_reg <= wdata;
                if (waddr == REG_A2) a2_reg <= wdata;
                if (waddr == REG_A7) a7_reg <= wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b_reg    <= q_head;
            fwd1_reg <= wen && waddr == q_head.rs1;
            fwd2_reg <= wen && waddr == q_head.rs2;
            vld1_reg <= vbits_reg[q_head.rs1];
            vld2_reg <= vbits_reg[q_head.rs2];
            fdat_reg <= wdata;
        end
        if (fire) begin
            st_reg    <= st;
            npc_reg   <= npc;
            mop_reg   <= mop;
            msz_reg   <= msz;
            maddr_reg <= maddr;
            wd_reg    <= wd;
            ss_reg    <= ss;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = st_reg;
    assign m_next_pc    = npc_reg;
    assign m_mem_op     = mop_reg;
    assign m_mem_size   = msz_reg;
    assign m_mem_addr   = maddr_reg;
    assign m_mem_wdata  = wd_reg;
    assign m_stream_sel = ss_reg;
endmodule

// File: hw/rtl/rv32i_execute_unit.sv
// top level of the rv32i execute unit: front, queue and back
// depends on rvx_pkg, rvx_front, rvx_queue, rvx_back, rvx_ram
//
//  beat   | direction | ports
//  s_     | in        | mode, instr, instr_addr, load_data
//  m_     | out       | status, next_pc, mem_op, mem_size, mem_addr, mem_wdata, stream_sel
//
// one instruction or load return a cycle sustained while m_ready is held high; an input
// beat passes the queue, the register file read register and the output register
// before its result beat; register file reads are registered with a one-deep bypass
// from write back; synchronous active-low reset clears control state and the register file
// valid bits; s_ready drops only when the two-entry queue is full
module rv32i_execute_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_instr,
    input  logic [31:0] s_instr_addr,
    input  logic [31:0] s_load_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_next_pc,
    output logic [1:0]  m_mem_op,
    output logic [1:0]  m_mem_size,
    output logic [31:0] m_mem_addr,
    output logic [31:0] m_mem_wdata,
    output logic        m_stream_sel
);
    import rvx_pkg::*;

    qent_t           fr_ent, q_head;
    logic            q_ne, q_full, q_pop;
    logic [QC_W-1:0] q_count;
    bk_stat_t        bk_stat;

    assign s_ready = !q_full;

    rvx_front u_front (
        .s_mode(s_mode), .s_instr(s_instr), .s_instr_addr(s_instr_addr),
        .s_load_data(s_load_data), .ent(fr_ent)
    );

    rvx_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(s_valid && s_ready), .push_ent(fr_ent),
        .pop(q_pop), .not_empty(q_ne), .full(q_full), .count(q_count), .head(q_head)
    );

    rvx_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_ne), .q_head(q_head), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status), .m_next_pc(m_next_pc),
        .m_mem_op(m_mem_op), .m_mem_size(m_mem_size), .m_mem_addr(m_mem_addr),
        .m_mem_wdata(m_mem_wdata), .m_stream_sel(m_stream_sel), .stat(bk_stat)
    );

    a_no_x0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.wen |-> bk_stat.waddr != '0)
        else $error("write back to x0");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QC_W'(QUEUE_DEPTH))
        else $error("queue count overrun");

    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.fire |=> m_valid)
        else $error("executed beat without result");

    a_write_needs_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.wen |-> bk_stat.fire)
        else $error("register write outside execute");
endmodule

// File: verif/rv32i_execute_unit_chk.sv
// result checker for the rv32i execute unit: predicts each beat and compares
// depends on rvx_pkg; instantiated beside the block by rv32i_execute_unit_tb
module rv32i_execute_unit_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_instr,
    input  logic [31:0] s_instr_addr,
    input  logic [31:0] s_load_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [31:0] m_next_pc,
    input  logic [1:0]  m_mem_op,
    input  logic [1:0]  m_mem_size,
    input  logic [31:0] m_mem_addr,
    input  logic [31:0] m_mem_wdata,
    input  logic        m_stream_sel,
    output int          fail_count,
    output int          pending_results
);
    import rvx_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [1:0]  mem_size;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        stream_sel;
    } exec_res_t;

    logic [31:0] regs [32];
    logic [4:0]  ld_rd;
    logic [2:0]  ld_kind;
    exec_res_t   expected_q [$];

    function automatic logic [31:0] rget(logic [4:0] i);
        return (i == 0 || i >= REG_COUNT) ? 32'h0 : regs[i];
    endfunction

    task automatic rset(logic [4:0] i, logic [31:0] v);
        if (i != 0 && i < REG_COUNT) regs[i] = v;
    endtask

    function automatic logic [31:0] alu_calc(logic [2:0] f3, logic alt, logic [31:0] a,
                                             logic [31:0] b);
        case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return {31'h0, $signed(a) < $signed(b)};
            F3_SLTU: return {31'h0, a < b};
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    task automatic execute_beat(logic md, logic [31:0] ins, logic [31:0] pc,
                                logic [31:0] ld, output exec_res_t r);
        logic [6:0]  op;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a, b, iimm, simm, bimm, jimm, addr, v, nr, fd;
        logic        ill, tk;
        r = '0;
        r.next_pc = pc + 4;
        ill = 1'b0;
        if (md) begin
            r.next_pc = pc;
            if (ld_kind == PK_NONE || ld_kind > PK_LHU) begin
                r.status = ST_ILLEGAL;
            end else begin
                case (ld_kind)
                    PK_LB:   v = {{24{ld[7]}}, ld[7:0]};
                    PK_LH:   v = {{16{ld[15]}}, ld[15:0]};
                    PK_LBU:  v = {24'h0, ld[7:0]};
                    PK_LHU:  v = {16'h0, ld[15:0]};
                    default: v = ld;
                endcase
                rset(ld_rd, v);
                ld_kind = PK_NONE;
                ld_rd = 0;
            end
            return;
        end
        op = ins[6:0];
        rd = ins[11:7];
        f3 = ins[14:12];
        f7 = ins[31:25];
        a = rget(ins[19:15]);
        b = rget(ins[24:20]);
        iimm = {{20{ins[31]}}, ins[31:20]};
        simm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        bimm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        jimm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        case (op)
            OP_ALU_R:
                if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)))
                    rset(rd, alu_calc(f3, f7 == F7_ALT, a, b));
                else ill = 1'b1;
            OP_ALU_I:
                if (f3 == F3_SLL && f7 != F7_BASE) ill = 1'b1;
                else if (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT) ill = 1'b1;
                else rset(rd, alu_calc(f3, f3 == F3_SR && f7 == F7_ALT, a, iimm));
            OP_LOAD: begin
                addr = a + iimm;
                if (f3 == F3_LWX || f3 > F3_LHU) ill = 1'b1;
                else if ((f3[1:0] == SZ_HALF && addr[0]) ||
                         (f3[1:0] == SZ_WORD && addr[1:0] != 0)) begin
                    r.status = ST_MISALIGN; r.next_pc = pc;
                    r.mem_addr = addr; r.mem_size = f3[1:0];
                end else begin
                    r.mem_op = MOP_LOAD; r.mem_size = f3[1:0]; r.mem_addr = addr;
                    ld_rd = rd;
                    ld_kind = (f3 < F3_LWX) ? f3 + 3'd1 : f3;
                end
            end
            OP_STORE: begin
                addr = a + simm;
                if (f3 > F3_LW) ill = 1'b1;
                else if ((f3 == 1 && addr[0]) || (f3 == 2 && addr[1:0] != 0)) begin
                    r.status = ST_MISALIGN; r.next_pc = pc;
                    r.mem_addr = addr; r.mem_size = f3[1:0];
                end else begin
                    r.mem_op = MOP_STORE; r.mem_size = f3[1:0]; r.mem_addr = addr;
                    r.mem_wdata = (f3 == 0) ? (b & 32'hFF) : (f3 == 1) ? (b & 32'hFFFF) : b;
                end
            end
            OP_BRANCH: begin
                tk = 1'b0;
                case (f3)
                    F3_BEQ:  tk = a == b;
                    F3_BNE:  tk = a != b;
                    F3_BLT:  tk = $signed(a) < $signed(b);
                    F3_BGE:  tk = $signed(a) >= $signed(b);
                    F3_BLTU: tk = a < b;
                    F3_BGEU: tk = a >= b;
                    default: ill = 1'b1;
                endcase
                if (tk) r.next_pc = pc + bimm;
            end
            OP_JAL: begin
                rset(rd, pc + 4);
                r.next_pc = pc + jimm;
            end
            OP_JALR:
                if (f3 != 0) ill = 1'b1;
                else begin
                    r.next_pc = (a + iimm) & ~32'h1;
                    rset(rd, pc + 4);
                end
            OP_LUI:   rset(rd, {ins[31:12], 12'h0});
            OP_AUIPC: rset(rd, pc + {ins[31:12], 12'h0});
            OP_MISC:  ;
            OP_SYSTEM:
                if (ins == INSTR_EBREAK) r.status = ST_EBREAK;
                else if (ins == INSTR_ECALL) begin
                    nr = rget(REG_A7);
                    if (nr == CALL_WRITE) begin
                        fd = rget(REG_A0);
                        if (fd == FD_STDOUT || fd == FD_STDERR) begin
                            r.status = ST_WRITE;
                            r.stream_sel = fd == FD_STDERR;
                            r.mem_addr = rget(REG_A1);
                            r.mem_wdata = rget(REG_A2);
                            rset(REG_A0, r.mem_wdata);
                        end else begin
                            r.status = ST_BAD_STREAM; r.next_pc = pc;
                        end
                    end else if (nr == CALL_EXIT) begin
                        r.status = ST_EXIT;
                        r.mem_wdata = rget(REG_A0);
                    end else begin
                        r.status = ST_UNKNOWN; r.next_pc = pc; r.mem_wdata = nr;
                    end
                end else ill = 1'b1;
            default: ill = 1'b1;
        endcase
        if (ill) begin
            r = '0;
            r.status = ST_ILLEGAL;
            r.next_pc = pc;
        end
    endtask

    always @(posedge aclk) begin
        exec_res_t r, e;
        if (!aresetn) begin
            foreach (regs[i]) regs[i] = '0;
            ld_rd = 0;
            ld_kind = PK_NONE;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_status !== e.status) begin
                        $error("status: expected %0d actual %0d", e.status, m_status);
                        fail_count++;
                    end
                    if (m_next_pc !== e.next_pc) begin
                        $error("next_pc: expected %h actual %h", e.next_pc, m_next_pc);
                        fail_count++;
                    end
                    if (m_mem_op !== e.mem_op) begin
                        $error("mem_op: expected %0d actual %0d", e.mem_op, m_mem_op);
                        fail_count++;
                    end
                    if (m_mem_size !== e.mem_size) begin
                        $error("mem_size: expected %0d actual %0d", e.mem_size, m_mem_size);
                        fail_count++;
                    end
                    if (m_mem_addr !== e.mem_addr) begin
                        $error("mem_addr: expected %h actual %h", e.mem_addr, m_mem_addr);
                        fail_count++;
                    end
                    if (m_mem_wdata !== e.mem_wdata) begin
                        $error("mem_wdata: expected %h actual %h", e.mem_wdata, m_mem_wdata);
                        fail_count++;
                    end
                    if (m_stream_sel !== e.stream_sel) begin
                        $error("stream_sel: expected %0d actual %0d", e.stream_sel,
                               m_stream_sel);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                execute_beat(s_mode, s_instr, s_instr_addr, s_load_data, r);
                expected_q.push_back(r);
            end
        end
        pending_results = expected_q.size();
    end

endmodule

// File: verif/rv32i_execute_unit_tb.sv
// testbench top for the rv32i execute unit: clock, reset, stimulus and verdict
// depends on rvx_pkg, rv32i_execute_unit and rv32i_execute_unit_chk
module rv32i_execute_unit_tb;
    import rvx_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [31:0] s_instr = '0;
    logic [31:0] s_instr_addr = '0;
    logic [31:0] s_load_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_next_pc;
    logic [1:0]  m_mem_op;
    logic [1:0]  m_mem_size;
    logic [31:0] m_mem_addr;
    logic [31:0] m_mem_wdata;
    logic        m_stream_sel;
    int          fail_count;
    int          pending_results;
    int          send_idle = 0;
    int          recv_stall = 0;

    always #5 aclk = ~aclk;

    rv32i_execute_unit dut (.*);
    rv32i_execute_unit_chk chk (.*);

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_beat(logic md, logic [31:0] ins, logic [31:0] ld);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= md;
        s_instr <= ins;
        s_instr_addr <= ($urandom_range(3) == 0) ? $urandom() :
                        {30'($urandom_range(255)), 2'b00};
        s_load_data <= (ld != '0) ? ld : $urandom();
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(15, 10));
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        logic [2:0]  f3;
        w = $urandom();
        f3 = w[14:12];
        w[19:15] = pick_reg();
        w[24:20] = pick_reg();
        w[11:7] = pick_reg();
        case ($urandom_range(13))
            0: begin w[6:0] = OP_ALU_R; w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE; end
            1: begin
                w[6:0] = OP_ALU_I;
                if (f3 == F3_SLL || f3 == F3_SR)
                    w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
            end
            2: begin w[6:0] = OP_LOAD; w[31:20] = $urandom_range(1) ? 12'h0 : w[31:20]; end
            3: begin w[6:0] = OP_STORE; w[14] = 1'b0; end
            4: w[6:0] = OP_BRANCH;
            5: w[6:0] = OP_JAL;
            6: w[6:0] = OP_JALR;
            7: w[6:0] = OP_LUI;
            8: w[6:0] = OP_AUIPC;
            9: w[6:0] = OP_MISC;
            10: w = $urandom_range(1) ? INSTR_ECALL : INSTR_EBREAK;
            11: begin w[6:0] = OP_ALU_I; w[14:12] = F3_ADD; w[11:7] = 5'($urandom_range(17, 10)); end
            12: begin
                w[6:0] = OP_ALU_I; w[14:12] = F3_ADD; w[19:15] = 5'd0;
                w[11:7] = $urandom_range(1) ? REG_A7 : REG_A0;
                w[31:20] = $urandom_range(1) ? CALL_WRITE[11:0] :
                           $urandom_range(1) ? CALL_EXIT[11:0] : 12'($urandom_range(3));
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic addi(logic [4:0] rd, logic [11:0] imm);
        send_beat(1'b0, {imm, 5'd0, F3_ADD, rd, OP_ALU_I}, 0);
    endtask

    initial begin
        logic [31:0] directed [$];
        int          phase;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: extremes, every class but valid stores and jalr, and the system calls
        send_beat(1'b1, 32'h0, 0);
        addi(5'd1, 12'h800);
        addi(5'd2, 12'h7FF);
        directed = '{
            {F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd3, OP_ALU_R},
            {F7_ALT, 5'd2, 5'd1, F3_SR, 5'd4, OP_ALU_R},
            {F7_ALT, 5'd31, 5'd1, F3_SR, 5'd5, OP_ALU_I},
            {7'h01, 5'd2, 5'd1, F3_ADD, 5'd6, OP_ALU_R},
            {12'hFFF, 5'd1, F3_LW, 5'd7, OP_LOAD},
            {12'h000, 5'd0, F3_LWX, 5'd7, OP_LOAD},
            {12'h000, 5'd0, 3'd0, 5'd8, OP_LOAD},
            32'h0, 32'hFFFFFFFF,
            {7'h00, 5'd2, 5'd0, 3'd3, 5'd0, OP_STORE},
            {7'h7F, 5'd2, 5'd1, F3_BLT, 5'h1F, OP_BRANCH},
            {7'h00, 5'd2, 5'd1, 3'd2, 5'd0, OP_BRANCH},
            32'hFFFFF06F, {12'h0, 5'd1, 3'd1, 5'd9, OP_JALR},
            32'hFFFFF0B7, 32'h00000017, 32'hFFFFFFFF & {25'h1FFFFFF, OP_MISC},
            INSTR_EBREAK, INSTR_ECALL, 32'h00200073
        };
        foreach (directed[i]) begin
            send_beat(1'b0, directed[i], 0);
            if (directed[i][6:0] == OP_LOAD) send_beat(1'b1, 0, 0);
        end
        addi(REG_A7, CALL_WRITE[11:0]);
        addi(REG_A0, 12'd2);
        send_beat(1'b0, INSTR_ECALL, 0);
        addi(REG_A0, 12'd5);
        send_beat(1'b0, INSTR_ECALL, 0);
        addi(REG_A7, CALL_EXIT[11:0]);
        send_beat(1'b0, INSTR_ECALL, 0);
        for (int n = 0; n < 1250; n++) begin
            phase = (n / 100) % 4;
            send_idle = (phase == 1 || phase == 3) ? ((phase == 3) ? 21 : 48) : 0;
            recv_stall = (phase == 2 || phase == 3) ? ((phase == 3) ? 21 : 48) : 0;
            send_beat($urandom_range(5) == 0, rand_instr(), 0);
        end
        s_valid <= 1'b0;
        recv_stall = 0;
        while (pending_results != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && pending_results == 0)
            $display("rv32i_execute_unit test passed");
        else
            $display("rv32i_execute_unit test failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("rv32i_execute_unit test failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rvx_pkg.sv
hw/rtl/rvx_ram.sv
hw/rtl/rvx_front.sv
hw/rtl/rvx_queue.sv
hw/rtl/rvx_back.sv
hw/rtl/rv32i_execute_unit.sv
verif/rv32i_execute_unit_chk.sv
verif/rv32i_execute_unit_tb.sv
